/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk with rst_n as reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that an antecedent implies a consequent on the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ssdw_pkg.sv */
// ---------------------------------------------------------------------------
// ssdw_pkg
// Types and constants for the scaled serial DAC writer.
// ---------------------------------------------------------------------------
package ssdw_pkg;

    localparam int FRAME_BITS_DEF = 16;
    localparam int CHANNELS_DEF   = 3;

    localparam int CODE_W    = 16;
    localparam int FLOW_W    = 24;
    localparam int CHAN_W    = 2;
    localparam int PIN_W     = 3;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 24;
    localparam int PROD_W    = FLOW_W + CODE_W;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 32;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCALED = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DIRECT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL    = 1'd1;

    localparam logic [CODE_W-1:0] CODE_MAX          = 16'hFFFF;
    localparam logic [CODE_W-1:0] FULL_SCALE_RESET  = 16'hFFFF;
    localparam logic [FLOW_W-1:0] NOMINAL_RESET     = 24'd1;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SETUP   = 3'd1,
        PH_DATA    = 3'd2,
        PH_SYNCLOW = 3'd3,
        PH_CLKLOW  = 3'd4,
        PH_CLKHIGH = 3'd5,
        PH_SYNCEND = 3'd6,
        PH_LDACLOW = 3'd7
    } frame_phase_t;

    typedef enum logic [1:0] {
        CTL_IDLE = 2'd0,
        CTL_CHK  = 2'd1,
        CTL_DIV  = 2'd2
    } ctl_state_t;

endpackage

/* hw/rtl/scaled_serial_dac_writer_core.sv */
// ---------------------------------------------------------------------------
// scaled_serial_dac_writer_core
// Three-channel serial DAC writer with scaled or direct code and LDAC strobe.
// ---------------------------------------------------------------------------
// Each input transfer (tick, direct write, scaled write or rejected write)
// yields exactly one output transfer carrying the pin levels, busy flag,
// reject flag and last code. Ticks, direct writes and rejected writes are
// handled in the accept cycle and their result is registered. For a scaled
// write the 24x16 product is registered in the accept cycle, a check step
// tests for saturation, and sixteen restoring steps through one shared
// 25-bit subtractor form the quotient. The input side is not ready while
// the divider runs or while an untaken result would be overwritten.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scaled_serial_dac_writer_core #(
    parameter int FRAME_BITS = ssdw_pkg::FRAME_BITS_DEF,
    parameter int CHANNELS   = ssdw_pkg::CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] channel, [25:2] operand, [31:26] zero
    input  logic [ssdw_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] cmd
    input  logic [ssdw_pkg::CMD_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] sclk_pins, [5:3] sdin_pins, [8:6] sync_pins, [11:9] ldac_pins,
    // [12] busy_res, [13] rejected, [29:14] code_sent, [31:30] zero
    output logic [ssdw_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [ssdw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssdw_pkg::CFG_W-1:0]      cfg_data
);
    import ssdw_pkg::*;

    localparam int BC_W      = $clog2(FRAME_BITS + 1);
    localparam int DIV_CNT_W = $clog2(CODE_W);
    localparam logic [PIN_W-1:0] CHAN_MASK = PIN_W'((1 << CHANNELS) - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(CODE_W - 1);

    logic [CODE_W-1:0]     full_scale_reg, full_scale_next;
    logic [FLOW_W-1:0]     nominal_reg, nominal_next;

    ctl_state_t            ctl_state_reg, ctl_state_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [FLOW_W-1:0]     rem_reg, rem_next;
    logic                  ovf_reg, ovf_next;
    logic [CHAN_W-1:0]     wr_chan_reg, wr_chan_next;

    frame_phase_t          phase_reg, phase_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [CHAN_W-1:0]     chan_reg, chan_next;
    logic [BC_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic                  wait_reg, wait_next;
    logic [PIN_W-1:0]      sclk_reg, sclk_next;
    logic [PIN_W-1:0]      sdin_reg, sdin_next;
    logic [PIN_W-1:0]      sync_reg, sync_next;
    logic [PIN_W-1:0]      ldac_reg, ldac_next;
    logic [CODE_W-1:0]     last_code_reg, last_code_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic [CMD_W-1:0]      in_cmd;
    logic [CHAN_W-1:0]     in_chan;
    logic [FLOW_W-1:0]     in_operand;
    logic                  accept;
    logic                  is_write;
    logic                  reject;
    logic                  start_div;

    logic                  in_idle;
    logic                  chk_step;
    logic                  div_step;
    logic                  div_last;

    logic [FLOW_W:0]       sub_a;
    logic [FLOW_W+1:0]     sub_diff;
    logic                  sub_ge;
    logic [CODE_W-1:0]     quotient;
    logic [CODE_W-1:0]     direct_code;

    assign in_cmd     = s_tuser;
    assign in_chan    = s_tdata[CHAN_W-1:0];
    assign in_operand = s_tdata[CHAN_W +: FLOW_W];

    assign accept    = s_tvalid && s_tready;
    assign is_write  = (in_cmd == CMD_SCALED) || (in_cmd == CMD_DIRECT);
    assign reject    = (phase_reg != PH_IDLE) || (32'(in_chan) >= 32'(CHANNELS));
    assign start_div = accept && (in_cmd == CMD_SCALED) && !reject;

    // Sequencer next state
    always_comb
    begin
        ctl_state_next = ctl_state_reg;
        unique case (ctl_state_reg)
            CTL_IDLE:
            begin
                if (start_div)
                    ctl_state_next = CTL_CHK;
            end
            CTL_CHK:
                ctl_state_next = CTL_DIV;
            CTL_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                    ctl_state_next = CTL_IDLE;
            end
            default:
                ctl_state_next = CTL_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_idle  = 1'b0;
        chk_step = 1'b0;
        div_step = 1'b0;
        div_last = 1'b0;
        unique case (ctl_state_reg)
            CTL_IDLE:
                in_idle = 1'b1;
            CTL_CHK:
                chk_step = 1'b1;
            CTL_DIV:
            begin
                div_step = 1'b1;
                div_last = (div_cnt_reg == DIV_LAST);
            end
            default:
                in_idle = 1'b0;
        endcase
    end

    assign s_tready = in_idle && (!m_tvalid_reg || m_tready);

    // Shared compare and subtract unit
    assign sub_a    = chk_step ? {1'b0, prod_reg[PROD_W-1:CODE_W]}
                               : {rem_reg, prod_reg[CODE_W-1]};
    assign sub_diff = {1'b0, sub_a} - {2'b00, nominal_reg};
    assign sub_ge   = !sub_diff[FLOW_W+1];
    assign quotient = {prod_reg[CODE_W-2:0], sub_ge};

    assign direct_code = (|in_operand[FLOW_W-1:CODE_W]) ? CODE_MAX
                                                        : in_operand[CODE_W-1:0];

    always_comb
    begin
        logic [PIN_W-1:0]  oh;
        logic              commit;
        logic              load_out;
        logic              rej_out;
        logic [CODE_W-1:0] wcode;
        logic [CHAN_W-1:0] wchan;
        logic [BC_W-1:0]   bc_dec;

        full_scale_next = full_scale_reg;
        nominal_next    = nominal_reg;
        div_cnt_next    = div_cnt_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        ovf_next        = ovf_reg;
        wr_chan_next    = wr_chan_reg;
        phase_next      = phase_reg;
        shift_next      = shift_reg;
        chan_next       = chan_reg;
        bit_cnt_next    = bit_cnt_reg;
        wait_next       = wait_reg;
        sclk_next       = sclk_reg;
        sdin_next       = sdin_reg;
        sync_next       = sync_reg;
        ldac_next       = ldac_reg;
        last_code_next  = last_code_reg;
        commit          = 1'b0;
        load_out        = 1'b0;
        rej_out         = 1'b0;
        wcode           = direct_code;
        wchan           = in_chan;
        bc_dec          = bit_cnt_reg;
        oh              = CHAN_MASK & (PIN_W'(1) << chan_reg);

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FULL_SCALE: full_scale_next = cfg_data[CODE_W-1:0];
                REG_NOMINAL:    nominal_next    = cfg_data[FLOW_W-1:0];
                default:        nominal_next    = nominal_reg;
            endcase
        end

        if (start_div)
        begin
            prod_next    = PROD_W'(in_operand) * PROD_W'(full_scale_reg);
            wr_chan_next = in_chan;
            div_cnt_next = '0;
        end

        if (chk_step)
        begin
            ovf_next = sub_ge;
            rem_next = prod_reg[PROD_W-1:CODE_W];
        end

        if (div_step)
        begin
            rem_next     = sub_ge ? sub_diff[FLOW_W-1:0] : sub_a[FLOW_W-1:0];
            prod_next    = {prod_reg[PROD_W-2:0], sub_ge};
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            if (div_last)
            begin
                commit   = 1'b1;
                load_out = 1'b1;
                wcode    = ovf_reg ? CODE_MAX : quotient;
                wchan    = wr_chan_reg;
            end
        end

        if (accept)
        begin
            if (in_cmd == CMD_TICK)
            begin
                load_out = 1'b1;
                unique case (phase_reg)
                    PH_SETUP:
                    begin
                        sdin_next  = shift_reg[FRAME_BITS-1] ? (sdin_reg | oh)
                                                             : (sdin_reg & ~oh);
                        shift_next = {shift_reg[FRAME_BITS-2:0], 1'b0};
                        phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        sync_next  = sync_reg & ~oh;
                        phase_next = PH_SYNCLOW;
                    end
                    PH_SYNCLOW:
                    begin
                        sclk_next  = sclk_reg & ~oh;
                        wait_next  = 1'b1;
                        phase_next = PH_CLKLOW;
                    end
                    PH_CLKLOW:
                    begin
                        if (wait_reg)
                            wait_next = 1'b0;
                        else
                        begin
                            sclk_next  = sclk_reg | oh;
                            phase_next = PH_CLKHIGH;
                        end
                    end
                    PH_CLKHIGH:
                    begin
                        if (bit_cnt_reg != '0)
                            bc_dec = bit_cnt_reg - BC_W'(1);
                        bit_cnt_next = bc_dec;
                        if (bc_dec != '0)
                        begin
                            sdin_next  = shift_reg[FRAME_BITS-1] ? (sdin_reg | oh)
                                                                 : (sdin_reg & ~oh);
                            shift_next = {shift_reg[FRAME_BITS-2:0], 1'b0};
                            phase_next = PH_DATA;
                        end
                        else
                        begin
                            sync_next  = sync_reg | oh;
                            wait_next  = 1'b1;
                            phase_next = PH_SYNCEND;
                        end
                    end
                    PH_SYNCEND:
                    begin
                        if (wait_reg)
                            wait_next = 1'b0;
                        else
                        begin
                            ldac_next  = ldac_reg & ~oh;
                            wait_next  = 1'b1;
                            phase_next = PH_LDACLOW;
                        end
                    end
                    PH_LDACLOW:
                    begin
                        if (wait_reg)
                            wait_next = 1'b0;
                        else
                        begin
                            ldac_next  = ldac_reg | oh;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                        phase_next = phase_reg;
                endcase
            end
            else if (is_write && reject)
            begin
                load_out = 1'b1;
                rej_out  = 1'b1;
            end
            else if (in_cmd == CMD_DIRECT)
            begin
                load_out = 1'b1;
                commit   = 1'b1;
            end
            else if (in_cmd != CMD_SCALED)
                load_out = 1'b1;
        end

        if (commit)
        begin
            oh             = CHAN_MASK & (PIN_W'(1) << wchan);
            last_code_next = wcode;
            shift_next     = FRAME_BITS'(wcode);
            chan_next      = wchan;
            bit_cnt_next   = BC_W'(FRAME_BITS);
            wait_next      = 1'b0;
            sclk_next      = sclk_reg | oh;
            sync_next      = sync_reg | oh;
            ldac_next      = ldac_reg | oh;
            phase_next     = PH_SETUP;
        end

        m_tdata_next = m_tdata_reg;
        if (load_out)
            m_tdata_next = M_DATA_W'({last_code_next, rej_out,
                                      (phase_next != PH_IDLE),
                                      ldac_next, sync_next, sdin_next, sclk_next});

        if (load_out)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= FULL_SCALE_RESET;
            nominal_reg    <= NOMINAL_RESET;
            ctl_state_reg  <= CTL_IDLE;
            div_cnt_reg    <= '0;
            phase_reg      <= PH_IDLE;
            shift_reg      <= '0;
            chan_reg       <= '0;
            bit_cnt_reg    <= '0;
            wait_reg       <= 1'b0;
            sclk_reg       <= CHAN_MASK;
            sdin_reg       <= '0;
            sync_reg       <= CHAN_MASK;
            ldac_reg       <= CHAN_MASK;
            last_code_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            full_scale_reg <= full_scale_next;
            nominal_reg    <= nominal_next;
            ctl_state_reg  <= ctl_state_next;
            div_cnt_reg    <= div_cnt_next;
            phase_reg      <= phase_next;
            shift_reg      <= shift_next;
            chan_reg       <= chan_next;
            bit_cnt_reg    <= bit_cnt_next;
            wait_reg       <= wait_next;
            sclk_reg       <= sclk_next;
            sdin_reg       <= sdin_next;
            sync_reg       <= sync_next;
            ldac_reg       <= ldac_next;
            last_code_reg  <= last_code_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        ovf_reg     <= ovf_next;
        wr_chan_reg <= wr_chan_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_IMPL(a_div_out_empty, ctl_state_reg != CTL_IDLE, !m_tvalid_reg,
        "result pending while divider runs")
    `ASSERT_IMPL(a_idle_pins_high, phase_reg == PH_IDLE,
        (sclk_reg == CHAN_MASK) && (sync_reg == CHAN_MASK) && (ldac_reg == CHAN_MASK),
        "control pins not released while idle")
    `ASSERT_CLK(a_one_ldac_low, $onehot0(~ldac_reg & CHAN_MASK),
        "more than one LDAC low")
    `ASSERT_IMPL(a_frame_chan_valid, phase_reg != PH_IDLE,
        32'(chan_reg) < 32'(CHANNELS), "frame on channel out of range")
    `ASSERT_IMPL(a_div_frame_idle, ctl_state_reg != CTL_IDLE, phase_reg == PH_IDLE,
        "divider running during a frame")

endmodule
